>>> design/ftnsl_pkg.sv
// Types and constants shared by the filtered top-N score list.
package ftnsl_pkg;

   localparam int MAX_OUT = 8;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 16;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_OFFER = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [CSR_IW-1:0] REG_WANT_SETLIST   = 3'd0;
   localparam logic [CSR_IW-1:0] REG_WANT_SONG      = 3'd1;
   localparam logic [CSR_IW-1:0] REG_WANT_DIFF      = 3'd2;
   localparam logic [CSR_IW-1:0] REG_DIFF_FILTER_ON = 3'd3;
   localparam logic [CSR_IW-1:0] REG_WANT_AFFIL     = 3'd4;
   localparam logic [CSR_IW-1:0] REG_AFFIL_FILTER_ON = 3'd5;
   localparam logic [CSR_IW-1:0] REG_LIST_LIMIT     = 3'd6;

   localparam logic [3:0] LIST_LIMIT_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] row_setlist;
      logic [7:0]  row_song;
      logic [3:0]  row_difficulty;
      logic        row_affiliation;
      logic [31:0] row_score;
      logic [15:0] row_player;
      logic [31:0] row_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  rank;
      logic        entry_valid;
      logic [15:0] out_player;
      logic [31:0] out_score;
      logic [31:0] out_time;
      logic [3:0]  held_count;
      logic        last_entry;
   } rsp_type;

   typedef struct packed {
      logic [15:0] want_setlist;
      logic [7:0]  want_song;
      logic [3:0]  want_difficulty;
      logic        difficulty_filter_on;
      logic        want_affiliation;
      logic        affiliation_filter_on;
      logic [3:0]  list_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] score;
      logic [15:0] player;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

>>> design/ftnsl_cell.sv
// One slot of the ranked list: compare against the offered score, insert, shift or rotate.
module ftnsl_cell import ftnsl_pkg::*; #(
   parameter int IDX = 0,
   parameter int CW  = 4
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] fill,
   input  logic          prev_gt,
   input  entry_type     prev_entry,
   input  entry_type     next_entry,
   output logic          gt,
   output entry_type     entry
);

   entry_type entry_ff, entry_in;
   logic      below_fill, at_fill, shift_in;

   always_comb begin
      below_fill = CW'(IDX) < fill;
      at_fill    = CW'(IDX) == fill;
      gt         = below_fill && (ctrl.new_entry.score > entry_ff.score);
      // list is sorted, so a new row lands above us if it beat the upper neighbor's score
      shift_in   = prev_gt || (CW'(IDX) > fill);
      entry_in   = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (shift_in) begin
               entry_in = prev_entry;
            end else if (gt || at_fill) begin
               entry_in = ctrl.new_entry;
            end
         end
         CELL_ROTATE: entry_in = next_entry;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> design/filtered_top_n_score_list.sv
// Top level of the filtered top-N score list: config, control and the cell chain.
// A clear empties the list in the cycle it is accepted; an offered row is filtered and
// inserted by a chain of compare-and-shift cells in the cycle it is accepted, so busy
// stays low. A read-out rotates the whole chain through cell 0 and keeps busy high
// until the rotation is complete (the rotation restores the order); results come one
// per cycle, each in the cycle after its entry reaches cell 0, and cannot be stalled.
// Reading an empty list gives one result the cycle after start and does not raise busy.
module filtered_top_n_score_list import ftnsl_pkg::*; #(
   parameter int LIST_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int SW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LW = (CW > 4) ? CW : 4;

   cfg_type       cfg_ff, cfg_in;
   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [CW-1:0] total_ff, total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept, match, insert_en, any_gt;
   logic [LW-1:0] lim_lw, total_lw, fill_lw, nout_lw;
   logic [CW-1:0] fill;
   cell_ctrl_type ctrl;
   logic          gt_vec [LIST_DEPTH];
   entry_type     entry_arr [LIST_DEPTH];

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = (state_ff == ST_READ);

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WANT_SETLIST:    cfg_in.want_setlist = csr_data;
            REG_WANT_SONG:       cfg_in.want_song = csr_data[7:0];
            REG_WANT_DIFF:       cfg_in.want_difficulty = csr_data[3:0];
            REG_DIFF_FILTER_ON:  cfg_in.difficulty_filter_on = csr_data[0];
            REG_WANT_AFFIL:      cfg_in.want_affiliation = csr_data[0];
            REG_AFFIL_FILTER_ON: cfg_in.affiliation_filter_on = csr_data[0];
            REG_LIST_LIMIT:      cfg_in.list_limit = csr_data[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // effective limit, held count truncated to it, read-out count and row filter
   always_comb begin
      lim_lw   = (LW'(cfg_ff.list_limit) > LW'(LIST_DEPTH)) ? LW'(LIST_DEPTH)
                                                             : LW'(cfg_ff.list_limit);
      total_lw = LW'(total_ff);
      fill_lw  = (total_lw > lim_lw) ? lim_lw : total_lw;
      fill     = CW'(fill_lw);
      nout_lw  = (total_lw > LW'(MAX_OUT)) ? LW'(MAX_OUT) : total_lw;
      match    = (req_data.row_setlist == cfg_ff.want_setlist)
              && (req_data.row_song == cfg_ff.want_song)
              && (!cfg_ff.difficulty_filter_on
                  || req_data.row_difficulty == cfg_ff.want_difficulty)
              && (!cfg_ff.affiliation_filter_on
                  || req_data.row_affiliation == cfg_ff.want_affiliation);
   end

   always_comb begin
      any_gt = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         any_gt = any_gt | gt_vec[i];
      end
   end

   always_comb begin
      insert_en = accept && (req_data.action == ACT_OFFER) && match
               && ((fill_lw < lim_lw) || any_gt);
      ctrl.new_entry.score  = req_data.row_score;
      ctrl.new_entry.player = req_data.row_player;
      ctrl.new_entry.stamp  = req_data.row_time;
      if (insert_en) begin
         ctrl.op = CELL_INSERT;
      end else if (state_ff == ST_READ) begin
         ctrl.op = CELL_ROTATE;
      end else begin
         ctrl.op = CELL_HOLD;
      end
   end

   // control FSM, count and result register
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_CLEAR: total_in = '0;
                  ACT_OFFER: begin
                     total_in = fill;
                     if (insert_en && (fill_lw < lim_lw)) begin
                        total_in = CW'(fill_lw + LW'(1));
                     end
                  end
                  ACT_READ: begin
                     if (total_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                        rsp_in.last_entry = 1'b1;
                     end else begin
                        state_in = ST_READ;
                        step_in  = '0;
                     end
                  end
                  default: total_in = total_ff;
               endcase
            end
         end
         ST_READ: begin
            if (LW'(step_ff) < nout_lw) begin
               rsp_valid_in       = 1'b1;
               rsp_in.rank        = 3'(step_ff);
               rsp_in.entry_valid = 1'b1;
               rsp_in.out_player  = entry_arr[0].player;
               rsp_in.out_score   = entry_arr[0].score;
               rsp_in.out_time    = entry_arr[0].stamp;
               rsp_in.held_count  = 4'(total_ff);
               rsp_in.last_entry  = (LW'(step_ff) + LW'(1)) == nout_lw;
            end
            if (step_ff == SW'(LIST_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff            <= '0;
         cfg_ff.list_limit <= LIST_LIMIT_RESET;
         state_ff          <= ST_IDLE;
         step_ff           <= '0;
         total_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic      prev_gt;
      entry_type prev_entry, next_entry;

      if (g == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_entry = ctrl.new_entry;
      end else begin : g_body
         assign prev_gt    = gt_vec[g-1];
         assign prev_entry = entry_arr[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_tail
         assign next_entry = entry_arr[0];
      end else begin : g_mid
         assign next_entry = entry_arr[g+1];
      end

      ftnsl_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .fill       (fill),
         .prev_gt    (prev_gt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .gt         (gt_vec[g]),
         .entry      (entry_arr[g])
      );
   end

endmodule

>>> design/ftnsl_checker.sv
// Port-level checks for the filtered top-N score list, bound to the top level.
module ftnsl_checker import ftnsl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an empty-list beat is the whole read-out
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |-> rsp_data.last_entry)
      else $error("empty-list beat without last_entry");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |->
         rsp_data.rank == 3'd0 && rsp_data.held_count == 4'd0)
      else $error("empty-list beat with nonzero rank or count");

   // read-out beats are back to back with rising rank
   a_rank_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_entry |=>
         rsp_valid && rsp_data.rank == $past(rsp_data.rank) + 3'd1)
      else $error("read-out beat missing or out of order");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action != ACT_READ |=> !rsp_valid)
      else $error("result after a clear or offer");

endmodule

bind filtered_top_n_score_list ftnsl_checker u_ftnsl_checker (.*);
